/* src/buddy_block_allocator_macros.svh */
// Assertion macros used by the buddy block allocator sequencer.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define BBA_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define BBA_ASSERT(lbl, prop, msg) \
   `BBA_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

/* src/bba_pkg.sv */
// Types, codes and helper functions of the buddy block allocator.
package bba_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [4:0] FLOOR_ORDER_RESET = 5'd4;
   localparam logic [4:0] CEIL_ORDER_RESET = 5'd20;
   localparam logic [31:0] MAX_REQUEST_SIZE_RESET = 32'd65536;
   localparam logic [7:0] HEADER_SIZE_RESET = 8'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOOR_ORDER,
      CSR_CEIL_ORDER,
      CSR_MAX_REQUEST_SIZE,
      CSR_HEADER_SIZE
   } csr_index_type;

   typedef enum logic {
      REQ_ALLOC,
      REQ_FREE
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_TOO_LARGE,
      STATUS_NO_MEMORY,
      STATUS_STACK_FULL
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_SELECT,
      S_SCAN,
      S_POP_CNT,
      S_POP_READ,
      S_POP_DATA,
      S_SPLIT_CNT,
      S_SPLIT_WRITE,
      S_PUSH_CNT,
      S_PUSH_WRITE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [4:0]  floor_order;
      logic [4:0]  ceil_order;
      logic [31:0] max_request_size;
      logic [7:0]  header_size;
   } cfg_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [31:0]  request_size;
      logic [31:0]  block_address;
      logic [4:0]   block_order;
   } req_item_type;

   typedef struct packed {
      logic [31:0] user_address;
      status_type  status;
   } rsp_item_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ctrl_status_type;

   // Rounds a byte count up to the order of the next power of two.
   function automatic logic [5:0] round_order(input logic [32:0] total);
      logic [5:0] msb;
      logic not_pow2;
      msb = '0;
      for (int i = 0; i < 33; i++) begin
         if (total[i]) begin
            msb = 6'(i);
         end
      end
      not_pow2 = (total & (total - 33'd1)) != '0;
      return msb + {5'd0, not_pow2};
   endfunction

endpackage

/* src/bba_if.sv */
// Request and response channel interfaces of the buddy block allocator.
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] request_size;
   logic [31:0] block_address;
   logic [4:0]  block_order;

   modport source (output valid, output req_type, output request_size,
                   output block_address, output block_order, input ready);
   modport sink (input valid, input req_type, input request_size,
                 input block_address, input block_order, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] user_address;
   logic [1:0]  status;

   modport source (output valid, output user_address, output status, input ready);
   modport sink (input valid, input user_address, input status, output ready);
endinterface

/* src/buddy_block_allocator.sv */
// Top level of the buddy block allocator: configuration registers and response register.
// A request is rejected at once or after a vain scan of higher stacks; a free is pushed on its stack,
// and an allocation pops a block and splits it down order by order. One request is in flight at a
// time and the next is accepted once the response is registered and the sequencer is back in idle.
// Synchronous reset empties all stacks and loads the configuration reset values.
module buddy_block_allocator #(
   parameter int ORDER_COUNT = 32,
   parameter int STACK_DEPTH = 64,
   parameter int ADDR_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   bba_req_if.sink                          req_bus,
   bba_rsp_if.source                        rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import bba_pkg::*;

   logic [4:0]  floor_order_ff;
   logic [4:0]  ceil_order_ff;
   logic [31:0] max_request_size_ff;
   logic [7:0]  header_size_ff;
   logic        rsp_valid_ff;
   rsp_item_type rsp_data_ff;

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type stat;
   req_item_type    req_item;
   rsp_item_type    rsp_item;

   assign cfg.floor_order = floor_order_ff;
   assign cfg.ceil_order = ceil_order_ff;
   assign cfg.max_request_size = max_request_size_ff;
   assign cfg.header_size = header_size_ff;

   assign req_item.req_type = req_kind_type'(req_bus.req_type);
   assign req_item.request_size = req_bus.request_size;
   assign req_item.block_address = req_bus.block_address;
   assign req_item.block_order = req_bus.block_order;

   assign cmd.start = req_bus.valid && stat.idle;
   assign cmd.out_free = !rsp_valid_ff || rsp_bus.ready;

   bba_ctrl #(
      .ORDER_COUNT (ORDER_COUNT),
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_item (req_item),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_order_ff <= FLOOR_ORDER_RESET;
         ceil_order_ff <= CEIL_ORDER_RESET;
         max_request_size_ff <= MAX_REQUEST_SIZE_RESET;
         header_size_ff <= HEADER_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stat.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FLOOR_ORDER: begin
                  floor_order_ff <= csr_wr_data[4:0];
               end
               CSR_CEIL_ORDER: begin
                  ceil_order_ff <= csr_wr_data[4:0];
               end
               CSR_MAX_REQUEST_SIZE: begin
                  max_request_size_ff <= csr_wr_data;
               end
               CSR_HEADER_SIZE: begin
                  header_size_ff <= csr_wr_data[7:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff <= rsp_item;
      end
   end

   assign req_bus.ready = stat.idle;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.user_address = rsp_data_ff.user_address;
   assign rsp_bus.status = rsp_data_ff.status;
endmodule

/* src/bba_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/bba_ctrl.sv */
// Sequencer of the buddy block allocator with its free stack and count memories.
`include "buddy_block_allocator_macros.svh"

module bba_ctrl #(
   parameter int ORDER_COUNT = 32,
   parameter int STACK_DEPTH = 64,
   parameter int ADDR_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bba_pkg::cfg_type         cfg,
   input  bba_pkg::ctrl_cmd_type    cmd,
   input  bba_pkg::req_item_type    req_item,
   output bba_pkg::ctrl_status_type stat,
   output bba_pkg::rsp_item_type    rsp_item
);
   import bba_pkg::*;

   localparam int ORD_W = $clog2(ORDER_COUNT);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int STK_DEPTH = ORDER_COUNT * STACK_DEPTH;
   localparam int STK_AW = $clog2(STK_DEPTH);
   localparam logic [6:0] ORDER_LIMIT = 7'(ORDER_COUNT);
   localparam logic [6:0] TOP_ORDER = 7'(ORDER_COUNT - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   function automatic logic [STK_AW-1:0] stk_index(input logic [ORD_W-1:0] idx,
                                                   input logic [CNT_W-1:0] slot);
      return STK_AW'(STK_AW'(idx) * STK_AW'(STACK_DEPTH) + STK_AW'(slot));
   endfunction

   state_type state_ff, state_in;

   req_kind_type     kind_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [4:0]       border_ff;
   logic [32:0]      total_ff;
   logic             too_large_ff;
   logic [5:0]       rord_ff;

   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [ORD_W-1:0] cur_ff, cur_in;
   logic [ORD_W-1:0] limit_ff, limit_in;
   logic             any_full_ff, any_full_in;
   logic [ADDR_BITS-1:0] node_ff, node_in;
   status_type       status_ff, status_in;
   logic [31:0]      uaddr_ff, uaddr_in;

   logic [ORDER_COUNT-1:0] nonempty_ff, nonempty_in;
   logic [ORDER_COUNT-1:0] full_ff, full_in;
   logic [ORDER_COUNT-1:0] cnt_valid_ff, cnt_valid_in;
   logic             cnt_rvalid_ff;

   logic             cnt_we;
   logic [ORD_W-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
   logic             stk_we;
   logic [STK_AW-1:0] stk_waddr, stk_raddr;
   logic [ADDR_BITS-1:0] stk_wdata, stk_rdata;

   logic [CNT_W-1:0] cnt_cur, cnt_inc, cnt_dec;
   logic [ORD_W-1:0] split_dst, sel_idx, limit_sel, push_idx;
   logic [5:0]       ord_raised;
   logic             ord_too_big, ord_no_stack, push_full;
   logic [ADDR_BITS-1:0] half_addr, fin_sum;

   bba_ram #(.WIDTH(CNT_W), .DEPTH(ORDER_COUNT)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   bba_ram #(.WIDTH(ADDR_BITS), .DEPTH(STK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign cnt_cur = cnt_rvalid_ff ? cnt_rdata : '0;
   assign cnt_inc = CNT_W'(cnt_cur + 1'b1);
   assign cnt_dec = CNT_W'(cnt_cur - 1'b1);
   assign split_dst = ORD_W'(cur_ff - 1'b1);

   assign ord_raised = (rord_ff < {1'b0, cfg.floor_order}) ? {1'b0, cfg.floor_order}
                                                             : rord_ff;
   assign ord_too_big = (rord_ff >= {1'b0, cfg.floor_order})
                        && (rord_ff > {1'b0, cfg.ceil_order});
   assign ord_no_stack = {1'b0, ord_raised} >= ORDER_LIMIT;
   assign sel_idx = ORD_W'(ord_raised);
   assign limit_sel = ({2'b00, cfg.ceil_order} > TOP_ORDER) ? ORD_W'(TOP_ORDER)
                                                            : ORD_W'(cfg.ceil_order);
   assign push_idx = ORD_W'(border_ff);
   assign push_full = ({2'b00, border_ff} >= ORDER_LIMIT) || full_ff[push_idx];

   assign half_addr = node_ff + (ADDR_BITS'(1) << split_dst);
   assign fin_sum = ((state_ff == S_POP_DATA) ? stk_rdata : node_ff)
                    + ADDR_BITS'(cfg.header_size);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            if (kind_ff == REQ_FREE) begin
               state_in = push_full ? S_FINISH : S_PUSH_CNT;
            end else if (too_large_ff || ord_too_big || ord_no_stack) begin
               state_in = S_FINISH;
            end else if (nonempty_ff[sel_idx]) begin
               state_in = S_POP_CNT;
            end else if (sel_idx >= limit_sel) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (nonempty_ff[cur_ff]) begin
               state_in = any_full_ff ? S_FINISH : S_POP_CNT;
            end else if (cur_ff == limit_ff) begin
               state_in = S_FINISH;
            end
         end
         S_POP_CNT: begin
            state_in = S_POP_READ;
         end
         S_POP_READ: begin
            state_in = S_POP_DATA;
         end
         S_POP_DATA: begin
            state_in = (cur_ff == ord_ff) ? S_FINISH : S_SPLIT_CNT;
         end
         S_SPLIT_CNT: begin
            state_in = S_SPLIT_WRITE;
         end
         S_SPLIT_WRITE: begin
            state_in = (split_dst == ord_ff) ? S_FINISH : S_SPLIT_CNT;
         end
         S_PUSH_CNT: begin
            state_in = S_PUSH_WRITE;
         end
         S_PUSH_WRITE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (cmd.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      ord_in = ord_ff;
      limit_in = limit_ff;
      any_full_in = any_full_ff;
      node_in = node_ff;
      status_in = status_ff;
      uaddr_in = uaddr_ff;
      nonempty_in = nonempty_ff;
      full_in = full_ff;
      cnt_valid_in = cnt_valid_ff;
      cnt_we = 1'b0;
      cnt_waddr = cur_ff;
      cnt_wdata = cnt_inc;
      cnt_raddr = cur_ff;
      stk_we = 1'b0;
      stk_waddr = stk_index(cur_ff, cnt_cur);
      stk_wdata = addr_ff;
      stk_raddr = stk_index(cur_ff, cnt_dec);
      case (state_ff)
         S_SELECT: begin
            uaddr_in = '0;
            if (kind_ff == REQ_FREE) begin
               if (push_full) begin
                  status_in = STATUS_STACK_FULL;
               end else begin
                  status_in = STATUS_OK;
                  cur_in = push_idx;
               end
            end else if (too_large_ff || ord_too_big) begin
               status_in = STATUS_TOO_LARGE;
            end else begin
               status_in = STATUS_NO_MEMORY;
               if (!ord_no_stack) begin
                  ord_in = sel_idx;
                  cur_in = sel_idx;
                  limit_in = limit_sel;
                  any_full_in = full_ff[sel_idx];
                  if (!nonempty_ff[sel_idx] && (sel_idx < limit_sel)) begin
                     cur_in = ORD_W'(sel_idx + 1'b1);
                  end
               end
            end
         end
         S_SCAN: begin
            if (nonempty_ff[cur_ff]) begin
               if (any_full_ff) begin
                  status_in = STATUS_STACK_FULL;
               end
            end else begin
               any_full_in = any_full_ff | full_ff[cur_ff];
               if (cur_ff != limit_ff) begin
                  cur_in = ORD_W'(cur_ff + 1'b1);
               end
            end
         end
         S_POP_READ: begin
            cnt_we = 1'b1;
            cnt_wdata = cnt_dec;
            nonempty_in[cur_ff] = cnt_dec != '0;
            full_in[cur_ff] = 1'b0;
            cnt_valid_in[cur_ff] = 1'b1;
         end
         S_POP_DATA: begin
            node_in = stk_rdata;
            if (cur_ff == ord_ff) begin
               status_in = STATUS_OK;
               uaddr_in = 32'(fin_sum);
            end
         end
         S_SPLIT_CNT: begin
            cnt_raddr = split_dst;
         end
         S_SPLIT_WRITE: begin
            stk_we = 1'b1;
            stk_waddr = stk_index(split_dst, cnt_cur);
            stk_wdata = half_addr;
            cnt_we = 1'b1;
            cnt_waddr = split_dst;
            nonempty_in[split_dst] = 1'b1;
            full_in[split_dst] = cnt_inc == CNT_FULL;
            cnt_valid_in[split_dst] = 1'b1;
            cur_in = split_dst;
            if (split_dst == ord_ff) begin
               status_in = STATUS_OK;
               uaddr_in = 32'(fin_sum);
            end
         end
         S_PUSH_WRITE: begin
            stk_we = 1'b1;
            cnt_we = 1'b1;
            nonempty_in[cur_ff] = 1'b1;
            full_in[cur_ff] = cnt_inc == CNT_FULL;
            cnt_valid_in[cur_ff] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nonempty_ff <= '0;
         full_ff <= '0;
         cnt_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         nonempty_ff <= nonempty_in;
         full_ff <= full_in;
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_rvalid_ff <= cnt_valid_ff[cnt_raddr];
      rord_ff <= round_order(total_ff);
      ord_ff <= ord_in;
      cur_ff <= cur_in;
      limit_ff <= limit_in;
      any_full_ff <= any_full_in;
      node_ff <= node_in;
      status_ff <= status_in;
      uaddr_ff <= uaddr_in;
      if (cmd.start) begin
         kind_ff <= req_item.req_type;
         addr_ff <= ADDR_BITS'(req_item.block_address);
         border_ff <= req_item.block_order;
         total_ff <= {1'b0, req_item.request_size} + 33'(cfg.header_size);
         too_large_ff <= req_item.request_size > cfg.max_request_size;
      end
   end

   assign stat.idle = state_ff == S_IDLE;
   assign stat.done = (state_ff == S_FINISH) && cmd.out_free;
   assign rsp_item.user_address = uaddr_ff;
   assign rsp_item.status = status_ff;

   `BBA_ASSERT(a_full_is_nonempty, (full_ff & ~nonempty_ff) == '0, "Full stack marked empty.")
   `BBA_ASSERT(a_pop_nonempty, state_ff == S_POP_CNT |-> nonempty_ff[cur_ff], "Empty pop.")
   `BBA_ASSERT(a_pop_count, state_ff == S_POP_READ |-> cnt_cur != '0, "Pop count is zero.")
   `BBA_ASSERT(a_split_room, state_ff == S_SPLIT_WRITE |-> cnt_cur < CNT_FULL, "Split overflow.")
   `BBA_ASSERT(a_start_idle, cmd.start |=> state_ff == S_ROUND, "Start while busy.")
endmodule
